### design/rfps_pkg.sv
// Package for the rarest-first piece selector.
// Holds field widths, default sizes, function codes and the control state type.
// No dependencies.
package rfps_pkg;

  localparam int FUNC_W  = 3;
  localparam int SLOT_W  = 6;
  localparam int PIECE_W = 10;
  localparam int PEERS_W = 7;
  localparam int CNT_W   = 7;
  localparam int CFG_W   = 11;
  // Wide enough to hold any piece limit up to 65536.
  localparam int LIM_W   = 17;

  localparam int DEF_MAX_PIECES = 1024;
  localparam int DEF_MAX_PEERS  = 64;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 11'd1024;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD    = 3'd0,
    FN_REMOVE = 3'd1,
    FN_ANN    = 3'd2,
    FN_TAKE   = 3'd3,
    FN_GIVE   = 3'd4,
    FN_POLL   = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_SCAN,
    ST_TAKE,
    ST_RESP
  } state_t;

endpackage

### design/rfps_cmd_if.sv
// Command channel of the piece selector: valid/ready plus the command fields.
// Depends on rfps_pkg.
interface rfps_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [rfps_pkg::FUNC_W-1:0]  func;
  logic [rfps_pkg::SLOT_W-1:0]  peer_slot;
  logic [rfps_pkg::PIECE_W-1:0] piece_index;

  modport source(output valid, output func, output peer_slot, output piece_index,
                 input ready);
  modport sink(input valid, input func, input peer_slot, input piece_index,
               output ready);
endinterface

### design/rfps_res_if.sv
// Result channel of the piece selector: valid/ready plus the result fields.
// Depends on rfps_pkg.
interface rfps_res_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [rfps_pkg::PIECE_W-1:0] chosen_piece;
  logic [rfps_pkg::PEERS_W-1:0] known_peers;

  modport source(output valid, output found, output chosen_piece, output known_peers,
                 input ready);
  modport sink(input valid, input found, input chosen_piece, input known_peers,
               output ready);
endinterface

### design/rarest_first_piece_selector_top.sv
// Top level of the rarest-first piece selector.
// Depends on rfps_pkg, rfps_cmd_if, rfps_res_if and rfps_ram.

// Per-piece state (holder bitmap, holder count, announced and taken flags) lives in one
// synchronous RAM of MAX_PIECES words; peer slot flags and the peer count are registers.
// After reset the block clears the RAM, one word per cycle, with cmd.ready low. One item
// is handled at a time. Remove and ignored commands go from accept straight to the
// response state; announce, take and give back pass through a read-modify-write state
// first. Adding a new peer sweeps every RAM word to clear its column; a poll by a valid
// peer sweeps the first min(active_pieces, MAX_PIECES) words. Each sweep reads one word
// per cycle through the single RAM read port. The result register lets the next item
// be accepted while a result waits to be taken.
module rarest_first_piece_selector_top #(
  parameter int MAX_PIECES = rfps_pkg::DEF_MAX_PIECES,
  parameter int MAX_PEERS  = rfps_pkg::DEF_MAX_PEERS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [rfps_pkg::CFG_W-1:0]  cfg_data,
  rfps_cmd_if.sink                    cmd,
  rfps_res_if.source                  res
);

  localparam int AW      = $clog2(MAX_PIECES);
  localparam int CW      = rfps_pkg::CNT_W;
  localparam int LW      = rfps_pkg::LIM_W;
  localparam int DW      = MAX_PEERS + CW + 2;
  localparam int CNT_LSB = MAX_PEERS;
  localparam int ANN_BIT = MAX_PEERS + CW;
  localparam int TK_BIT  = ANN_BIT + 1;
  localparam logic [LW-1:0] MAXP_L = LW'(MAX_PIECES);
  localparam logic [MAX_PEERS-1:0] ONE_MASK = MAX_PEERS'(1);

  rfps_pkg::state_t state, state_next;

  logic [rfps_pkg::CFG_W-1:0]   active_pieces;
  logic [MAX_PEERS-1:0]         peer_valid;
  logic [rfps_pkg::PEERS_W-1:0] peer_total;

  rfps_pkg::func_t      cmd_op;
  logic [MAX_PEERS-1:0] cmd_mask;
  logic [AW-1:0]        cmd_addr;

  logic [LW-1:0] rd_cnt;
  logic [LW-1:0] scan_end;
  logic          s_valid;
  logic [AW-1:0] s_idx;

  logic          have;
  logic [AW-1:0] best_idx;
  logic [CW-1:0] best_cnt;
  logic [DW-1:0] best_word;

  logic                         res_found;
  logic [rfps_pkg::PIECE_W-1:0] res_chosen;
  logic                         out_vld;
  logic                         out_found;
  logic [rfps_pkg::PIECE_W-1:0] out_chosen;
  logic [rfps_pkg::PEERS_W-1:0] out_peers;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;

  logic [LW-1:0]        lim;
  logic                 accept;
  rfps_pkg::func_t      in_func;
  logic                 in_slot_ok;
  logic [MAX_PEERS-1:0] in_mask;
  logic                 in_peer_valid;
  logic [LW-1:0]        in_piece_l;
  logic                 in_piece_ok;
  logic [AW-1:0]        in_addr;
  logic                 go_scan;
  logic                 go_rmw;
  logic                 add_go;
  logic                 rem_go;

  logic                 issue;
  logic [MAX_PEERS-1:0] r_bits;
  logic [CW-1:0]        r_cnt;
  logic                 r_ann;
  logic                 r_tk;
  logic                 r_hit;
  logic                 better;
  logic [DW-1:0]        rmw_word;
  logic [DW-1:0]        clr_word;
  logic                 out_free;

  rfps_ram #(
    .DEPTH(MAX_PIECES),
    .AW   (AW),
    .DW   (DW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Command decode.
  always_comb begin
    lim = (LW'(active_pieces) < MAXP_L) ? LW'(active_pieces) : MAXP_L;
    accept        = cmd.valid && cmd.ready;
    in_func       = rfps_pkg::func_t'(cmd.func);
    in_slot_ok    = (rfps_pkg::PEERS_W'(cmd.peer_slot) < rfps_pkg::PEERS_W'(MAX_PEERS));
    in_mask       = ONE_MASK << cmd.peer_slot;
    in_peer_valid = |(peer_valid & in_mask);
    in_piece_l    = LW'(cmd.piece_index);
    in_piece_ok   = in_piece_l < lim;
    in_addr       = in_piece_l[AW-1:0];
    add_go        = in_slot_ok && !in_peer_valid;
    rem_go        = in_slot_ok && in_peer_valid;
    go_scan = 1'b0;
    go_rmw  = 1'b0;
    case (in_func)
      rfps_pkg::FN_ADD:  go_scan = add_go;
      rfps_pkg::FN_POLL: go_scan = in_slot_ok && in_peer_valid;
      rfps_pkg::FN_ANN:  go_rmw  = in_slot_ok && in_peer_valid && in_piece_ok;
      rfps_pkg::FN_TAKE: go_rmw  = in_slot_ok && in_piece_ok;
      rfps_pkg::FN_GIVE: go_rmw  = in_slot_ok && in_piece_ok;
      default: begin
        go_scan = 1'b0;
        go_rmw  = 1'b0;
      end
    endcase
  end

  // Read data decode and the modified words.
  always_comb begin
    issue    = rd_cnt < scan_end;
    r_bits   = mem_rdata[MAX_PEERS-1:0];
    r_cnt    = mem_rdata[CNT_LSB +: CW];
    r_ann    = mem_rdata[ANN_BIT];
    r_tk     = mem_rdata[TK_BIT];
    r_hit    = |(r_bits & cmd_mask);
    better   = r_ann && !r_tk && r_hit && (!have || (r_cnt < best_cnt));
    out_free = !out_vld || res.ready;

    rmw_word = mem_rdata;
    case (cmd_op)
      rfps_pkg::FN_ANN: begin
        if (!r_hit) begin
          rmw_word[MAX_PEERS-1:0] = r_bits | cmd_mask;
          rmw_word[CNT_LSB +: CW] = r_cnt + CW'(1);
        end
        rmw_word[ANN_BIT] = 1'b1;
      end
      rfps_pkg::FN_TAKE: rmw_word[TK_BIT] = 1'b1;
      rfps_pkg::FN_GIVE: rmw_word[TK_BIT] = 1'b0;
      default:           rmw_word = mem_rdata;
    endcase

    clr_word = mem_rdata;
    clr_word[MAX_PEERS-1:0] = r_bits & ~cmd_mask;
    clr_word[CNT_LSB +: CW] = r_cnt - CW'(r_hit);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      rfps_pkg::ST_CLEAR: begin
        if (rd_cnt == MAXP_L - LW'(1)) begin
          state_next = rfps_pkg::ST_IDLE;
        end
      end
      rfps_pkg::ST_IDLE: begin
        if (accept) begin
          if (go_scan) begin
            state_next = rfps_pkg::ST_SCAN;
          end else if (go_rmw) begin
            state_next = rfps_pkg::ST_RMW;
          end else begin
            state_next = rfps_pkg::ST_RESP;
          end
        end
      end
      rfps_pkg::ST_RMW:  state_next = rfps_pkg::ST_RESP;
      rfps_pkg::ST_SCAN: begin
        if (!issue && !s_valid) begin
          if (cmd_op == rfps_pkg::FN_POLL && have) begin
            state_next = rfps_pkg::ST_TAKE;
          end else begin
            state_next = rfps_pkg::ST_RESP;
          end
        end
      end
      rfps_pkg::ST_TAKE: state_next = rfps_pkg::ST_RESP;
      rfps_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = rfps_pkg::ST_IDLE;
        end
      end
      default: state_next = rfps_pkg::ST_IDLE;
    endcase
  end

  // RAM control and handshake outputs.
  always_comb begin
    cmd.ready = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = s_idx;
    mem_wdata = clr_word;
    mem_raddr = rd_cnt[AW-1:0];
    case (state)
      rfps_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = rd_cnt[AW-1:0];
        mem_wdata = '0;
      end
      rfps_pkg::ST_IDLE: begin
        cmd.ready = 1'b1;
        mem_raddr = in_addr;
      end
      rfps_pkg::ST_RMW: begin
        mem_we    = 1'b1;
        mem_waddr = cmd_addr;
        mem_wdata = rmw_word;
      end
      rfps_pkg::ST_SCAN: begin
        // The write trails the read by one word, so the two never meet.
        mem_we    = s_valid && (cmd_op == rfps_pkg::FN_ADD);
        mem_waddr = s_idx;
        mem_wdata = clr_word;
      end
      rfps_pkg::ST_TAKE: begin
        mem_we    = 1'b1;
        mem_waddr = best_idx;
        mem_wdata = best_word | (DW'(1) << TK_BIT);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rfps_pkg::ST_CLEAR;
      active_pieces <= rfps_pkg::ACTIVE_RESET;
      peer_valid    <= '0;
      peer_total    <= '0;
      rd_cnt        <= '0;
      s_valid       <= 1'b0;
      have          <= 1'b0;
      out_vld       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        active_pieces <= cfg_data;
      end
      case (state)
        rfps_pkg::ST_CLEAR: rd_cnt <= rd_cnt + LW'(1);
        rfps_pkg::ST_IDLE: begin
          if (accept) begin
            cmd_op     <= in_func;
            cmd_mask   <= in_mask;
            cmd_addr   <= in_addr;
            res_found  <= 1'b0;
            res_chosen <= '0;
            rd_cnt     <= '0;
            have       <= 1'b0;
            s_valid    <= 1'b0;
            scan_end   <= (in_func == rfps_pkg::FN_ADD) ? MAXP_L : lim;
            if (in_func == rfps_pkg::FN_ADD && add_go) begin
              peer_valid <= peer_valid | in_mask;
              peer_total <= peer_total + rfps_pkg::PEERS_W'(1);
            end
            if (in_func == rfps_pkg::FN_REMOVE && rem_go) begin
              peer_valid <= peer_valid & ~in_mask;
              peer_total <= peer_total - rfps_pkg::PEERS_W'(1);
            end
          end
        end
        rfps_pkg::ST_SCAN: begin
          s_valid <= issue;
          s_idx   <= rd_cnt[AW-1:0];
          if (issue) begin
            rd_cnt <= rd_cnt + LW'(1);
          end
          // Strict less-than keeps the lowest index on a tie.
          if (s_valid && cmd_op == rfps_pkg::FN_POLL && better) begin
            have      <= 1'b1;
            best_idx  <= s_idx;
            best_cnt  <= r_cnt;
            best_word <= mem_rdata;
          end
        end
        rfps_pkg::ST_TAKE: begin
          res_found  <= 1'b1;
          res_chosen <= rfps_pkg::PIECE_W'(best_idx);
        end
        default: begin
          s_valid <= 1'b0;
        end
      endcase
      if (state == rfps_pkg::ST_RESP && out_free) begin
        out_vld <= 1'b1;
      end else if (res.valid && res.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == rfps_pkg::ST_RESP && out_free) begin
      out_found  <= res_found;
      out_chosen <= res_chosen;
      out_peers  <= peer_total;
    end
  end

  assign res.valid        = out_vld;
  assign res.found        = out_found;
  assign res.chosen_piece = out_chosen;
  assign res.known_peers  = out_peers;

`ifndef NO_ASSERTIONS
  a_total_matches: assert property (@(posedge clk) disable iff (rst)
    peer_total == rfps_pkg::PEERS_W'($countones(peer_valid)))
    else $error("peer count differs from the number of valid slots");

  a_sweep_no_collide: assert property (@(posedge clk) disable iff (rst)
    (state == rfps_pkg::ST_SCAN && mem_we && issue) |-> (mem_waddr != mem_raddr))
    else $error("sweep write hit the word being read");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !cmd.ready)
    else $error("second item accepted while one is in progress");

  a_chosen_in_range: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.found) |-> (LW'(res.chosen_piece) < lim))
    else $error("chosen piece is outside the active range");
`endif

endmodule

### design/rfps_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
// No dependencies.
module rfps_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 73
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### dv/rarest_first_piece_selector_top_tb.sv
// Self-checking testbench for the rarest-first piece selector top level.
// Walks a directed command table, then random phases at several piece limits.
// Depends on rfps_pkg, rfps_cmd_if, rfps_res_if and rarest_first_piece_selector_top.
module rarest_first_piece_selector_top_tb;

  localparam int NPIECE = rfps_pkg::DEF_MAX_PIECES;
  localparam int NPEER  = rfps_pkg::DEF_MAX_PEERS;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic                           found;
    logic [rfps_pkg::PIECE_W-1:0]   chosen_piece;
    logic [rfps_pkg::PEERS_W-1:0]   known_peers;
  } answer_t;

  typedef struct {
    logic [rfps_pkg::FUNC_W-1:0]  fn;
    logic [rfps_pkg::SLOT_W-1:0]  slot;
    logic [rfps_pkg::PIECE_W-1:0] piece;
    bit                           typed;
    answer_t                      want;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [rfps_pkg::CFG_W-1:0] cfg_data = '0;

  rfps_cmd_if cmd ();
  rfps_res_if res ();

  rarest_first_piece_selector_top uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data), .cmd(cmd), .res(res)
  );

  // Shadow copy of the block's per-piece and per-peer state.
  logic [rfps_pkg::CNT_W-1:0]   holders_n [NPIECE];
  logic [NPEER-1:0]             holders_map [NPIECE];
  bit                           is_announced [NPIECE];
  bit                           is_taken [NPIECE];
  bit                           slot_in_use [NPEER];
  logic [rfps_pkg::PEERS_W-1:0] peer_count;
  logic [rfps_pkg::CFG_W-1:0]   active_reg;

  answer_t pending_answers[$];
  int  mismatches = 0;
  int  answers_seen = 0;
  int  polls_found = 0;
  bit  idling_on = 1'b1;
  int  cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    cmd.valid = 1'b0;
    cmd.func = '0;
    cmd.peer_slot = '0;
    cmd.piece_index = '0;
    res.ready = 1'b0;
  end

  // Apply one command to the shadow state and return the answer it produces.
  function automatic answer_t select_and_update(logic [rfps_pkg::FUNC_W-1:0] fn,
                                                logic [rfps_pkg::SLOT_W-1:0] slot,
                                                logic [rfps_pkg::PIECE_W-1:0] piece);
    int lim;
    int best;
    int best_n;
    bit have;
    answer_t a;
    lim = (active_reg < NPIECE) ? int'(active_reg) : NPIECE;
    a = '0;
    case (fn)
      rfps_pkg::FN_ADD: begin
        if (!slot_in_use[slot]) begin
          slot_in_use[slot] = 1'b1;
          peer_count++;
          for (int i = 0; i < NPIECE; i++) begin
            if (holders_map[i][slot]) begin
              holders_map[i][slot] = 1'b0;
              if (holders_n[i] != 0) holders_n[i]--;
            end
          end
        end
      end
      rfps_pkg::FN_REMOVE: begin
        if (slot_in_use[slot]) begin
          slot_in_use[slot] = 1'b0;
          if (peer_count != 0) peer_count--;
        end
      end
      rfps_pkg::FN_ANN: begin
        if (slot_in_use[slot] && piece < lim) begin
          if (!holders_map[piece][slot]) begin
            holders_map[piece][slot] = 1'b1;
            if (holders_n[piece] < NPEER) holders_n[piece]++;
          end
          is_announced[piece] = 1'b1;
        end
      end
      rfps_pkg::FN_TAKE: if (piece < lim) is_taken[piece] = 1'b1;
      rfps_pkg::FN_GIVE: if (piece < lim) is_taken[piece] = 1'b0;
      rfps_pkg::FN_POLL: begin
        if (slot_in_use[slot]) begin
          have = 1'b0;
          best = 0;
          best_n = 0;
          for (int i = 0; i < lim; i++) begin
            if (is_announced[i] && !is_taken[i] && holders_map[i][slot] &&
                (!have || holders_n[i] < best_n)) begin
              have = 1'b1;
              best = i;
              best_n = holders_n[i];
            end
          end
          if (have) begin
            is_taken[best] = 1'b1;
            a.found = 1'b1;
            a.chosen_piece = best[rfps_pkg::PIECE_W-1:0];
          end
        end
      end
      default: ;
    endcase
    a.known_peers = peer_count;
    return a;
  endfunction

  // Drive one command from the falling edge and wait until the block takes it.
  task automatic issue(step_t s);
    answer_t a;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      cmd.valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    cmd.valid = 1'b1;
    cmd.func = s.fn;
    cmd.peer_slot = s.slot;
    cmd.piece_index = s.piece;
    do @(posedge clk); while (!cmd.ready);
    a = select_and_update(s.fn, s.slot, s.piece);
    pending_answers.push_back(s.typed ? s.want : a);
  endtask

  task automatic drain_and_write(logic [rfps_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cmd.valid = 1'b0;
    wait (pending_answers.size() == 0);
    repeat (20) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = value;
    @(posedge clk);
    active_reg = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Mostly well-formed traffic on a few peers and on pieces below piece_span, which may pass the limit.
  task automatic random_phase(int count, int piece_span);
    step_t s;
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 8) s.fn = rfps_pkg::FN_ADD;
      else if (r < 14) s.fn = rfps_pkg::FN_REMOVE;
      else if (r < 50) s.fn = rfps_pkg::FN_ANN;
      else if (r < 60) s.fn = rfps_pkg::FN_TAKE;
      else if (r < 72) s.fn = rfps_pkg::FN_GIVE;
      else if (r < 97) s.fn = rfps_pkg::FN_POLL;
      else s.fn = rfps_pkg::FUNC_W'($urandom_range(6, 7));
      s.slot = ($urandom_range(0, 9) == 0) ? rfps_pkg::SLOT_W'($urandom)
                                           : rfps_pkg::SLOT_W'($urandom_range(0, 5));
      s.piece = ($urandom_range(0, 9) == 0) ? rfps_pkg::PIECE_W'($urandom)
                : rfps_pkg::PIECE_W'($urandom_range(0, piece_span - 1));
      s.typed = 1'b0;
      s.want = '0;
      issue(s);
    end
  endtask

  function automatic step_t row(logic [rfps_pkg::FUNC_W-1:0] fn, int slot, int piece,
                                bit typed, bit f, int cp, int kp);
    step_t s;
    s.fn = fn;
    s.slot = rfps_pkg::SLOT_W'(slot);
    s.piece = rfps_pkg::PIECE_W'(piece);
    s.typed = typed;
    s.want.found = f;
    s.want.chosen_piece = rfps_pkg::PIECE_W'(cp);
    s.want.known_peers = rfps_pkg::PEERS_W'(kp);
    return s;
  endfunction

  // Result side: random stall bursts, and a scoreboard check at each result taken.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        res.ready = 1'b0;
        stall--;
      end else begin
        res.ready = 1'b1;
        if (idling_on && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 11);
      end
    end
  end

  always @(posedge clk) begin
    answer_t exp_a;
    if (!rst && res.valid && res.ready) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        $error("result with nothing expected: found=%0d chosen_piece=%0d known_peers=%0d",
               res.found, res.chosen_piece, res.known_peers);
        mismatches++;
      end else begin
        exp_a = pending_answers.pop_front();
        if (res.found !== exp_a.found) begin
          $error("found: expected %0d, got %0d", exp_a.found, res.found);
          mismatches++;
        end
        if (res.chosen_piece !== exp_a.chosen_piece) begin
          $error("chosen_piece: expected %0d, got %0d", exp_a.chosen_piece, res.chosen_piece);
          mismatches++;
        end
        if (res.known_peers !== exp_a.known_peers) begin
          $error("known_peers: expected %0d, got %0d", exp_a.known_peers, res.known_peers);
          mismatches++;
        end
        if (exp_a.found) polls_found++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    step_t plan[$];
    for (int i = 0; i < NPIECE; i++) begin
      holders_n[i] = '0;
      holders_map[i] = '0;
      is_announced[i] = 1'b0;
      is_taken[i] = 1'b0;
    end
    for (int i = 0; i < NPEER; i++) slot_in_use[i] = 1'b0;
    peer_count = '0;
    active_reg = rfps_pkg::ACTIVE_RESET;

    // Directed walk: extreme slots and pieces, repeats, free peers and the rarest-first choice.
    plan.push_back(row(rfps_pkg::FN_POLL,   0,    0, 1, 0, 0, 0));
    plan.push_back(row(rfps_pkg::FN_ADD,    0,    0, 1, 0, 0, 1));
    plan.push_back(row(rfps_pkg::FN_ADD,   63,    0, 1, 0, 0, 2));
    plan.push_back(row(rfps_pkg::FN_ADD,    0,    0, 1, 0, 0, 2));
    plan.push_back(row(rfps_pkg::FN_ANN,    0, 1023, 1, 0, 0, 2));
    plan.push_back(row(rfps_pkg::FN_ANN,    0, 1023, 1, 0, 0, 2));
    plan.push_back(row(rfps_pkg::FN_ANN,   63, 1023, 1, 0, 0, 2));
    plan.push_back(row(rfps_pkg::FN_ANN,   63,    0, 1, 0, 0, 2));
    plan.push_back(row(rfps_pkg::FN_ANN,    5,    3, 1, 0, 0, 2));
    plan.push_back(row(rfps_pkg::FN_TAKE,  42,    5, 1, 0, 0, 2));
    plan.push_back(row(rfps_pkg::FN_POLL,  63,    0, 1, 1, 0, 2));
    plan.push_back(row(rfps_pkg::FN_POLL,  63,    0, 1, 1, 1023, 2));
    plan.push_back(row(rfps_pkg::FN_POLL,  63,    0, 1, 0, 0, 2));
    plan.push_back(row(rfps_pkg::FN_GIVE,  21, 1023, 1, 0, 0, 2));
    plan.push_back(row(rfps_pkg::FN_GIVE,  21,    5, 1, 0, 0, 2));
    plan.push_back(row(rfps_pkg::FN_GIVE,  21,    5, 1, 0, 0, 2));
    plan.push_back(row(rfps_pkg::FN_POLL,   0,  511, 0, 0, 0, 0));
    plan.push_back(row(3'd6,                0,    0, 1, 0, 0, 2));
    plan.push_back(row(3'd7,               63, 1023, 1, 0, 0, 2));
    plan.push_back(row(rfps_pkg::FN_REMOVE, 63,   0, 1, 0, 0, 1));
    plan.push_back(row(rfps_pkg::FN_REMOVE, 63,   0, 1, 0, 0, 1));
    plan.push_back(row(rfps_pkg::FN_GIVE,   0, 1023, 0, 0, 0, 0));
    plan.push_back(row(rfps_pkg::FN_ADD,   63,    0, 1, 0, 0, 2));
    plan.push_back(row(rfps_pkg::FN_POLL,  63,    0, 1, 0, 0, 2));
    plan.push_back(row(rfps_pkg::FN_POLL,   0,    0, 0, 0, 0, 0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) issue(plan[i]);

    drain_and_write(11'd16);
    random_phase(150, 20);
    drain_and_write(11'd1);
    random_phase(60, 3);
    drain_and_write(11'd40);
    random_phase(150, 48);
    drain_and_write(11'h7FF);
    random_phase(110, 1024);
    drain_and_write(11'd1024);
    idling_on = 1'b0;
    random_phase(90, 24);

    @(negedge clk);
    cmd.valid = 1'b0;
    wait (pending_answers.size() == 0);
    repeat (40) @(posedge clk);
    $display("checked %0d results, %0d polls returned a piece, limits 1024/16/1/40/2047",
             answers_seen, polls_found);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

### filelist.f
design/rfps_pkg.sv
design/rfps_cmd_if.sv
design/rfps_res_if.sv
design/rfps_ram.sv
design/rarest_first_piece_selector_top.sv
dv/rarest_first_piece_selector_top_tb.sv
